/* design/ptt_pkg.sv */
// Shared types, constants and control structures of the pending transaction tracker.
package ptt_pkg;

  localparam int PTT_MAX_PENDING = 16;
  localparam int ID_W            = 8;
  localparam int PAYLOAD_W       = 32;
  localparam int COUNT_OUT_W     = 5;

  typedef enum logic [1:0] {
    KIND_ADD        = 2'd0,
    KIND_FIND       = 2'd1,
    KIND_FIND_REM   = 2'd2,
    KIND_REM_FIRST  = 2'd3
  } ptt_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FINISH
  } ptt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load_op;
    logic idx_clear;
    logic idx_inc;
    logic mem_rd;
    logic rd_next;
    logic wr_add;
    logic wr_shift;
    logic head_inc;
    logic count_inc;
    logic count_dec;
    logic res_hit;
    logic res_add;
    logic res_ovf;
    logic out_load;
  } ptt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    ptt_kind_t op_kind;
    logic      full;
    logic      empty;
    logic      match;
    logic      last;
    logic      out_free;
  } ptt_sts_t;

endpackage

/* design/ptt_if.sv */
// Request and response channel interfaces of the pending transaction tracker.
interface ptt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  trans_id;
  logic [31:0] payload;

  modport source (output valid, output kind, output trans_id, output payload, input ready);
  modport sink   (input valid, input kind, input trans_id, input payload, output ready);
endinterface

interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  hit_id;
  logic [31:0] hit_payload;
  logic [4:0]  entry_count;
  logic        overflow;

  modport source (output valid, output found, output hit_id, output hit_payload,
                  output entry_count, output overflow, input ready);
  modport sink   (input valid, input found, input hit_id, input hit_payload,
                  input entry_count, input overflow, output ready);
endinterface

/* design/ptt_datapath.sv */
// Datapath: entry memory kept as a ring, head and count, scan index and result registers.
module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int MAX_PENDING = PTT_MAX_PENDING
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ptt_cmd_t               cmd,
  output ptt_sts_t               sts,
  input  logic [1:0]             in_kind,
  input  logic [ID_W-1:0]        in_trans_id,
  input  logic [PAYLOAD_W-1:0]   in_payload,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   found,
  output logic [ID_W-1:0]        hit_id,
  output logic [PAYLOAD_W-1:0]   hit_payload,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   overflow
);

  localparam int IW = $clog2(MAX_PENDING);
  localparam int CW = $clog2(MAX_PENDING + 1);
  localparam int SW = CW + 1;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PAYLOAD_W-1:0] pay;
  } entry_t;

  // Physical slot of logical position off, counted from the head.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(MAX_PENDING)) begin
      sum = sum - SW'(MAX_PENDING);
    end
    return sum[IW-1:0];
  endfunction

  entry_t               mem [MAX_PENDING];
  entry_t               rdata;
  entry_t               wr_data;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        wr_addr;
  logic                 wr_en;

  ptt_kind_t            op_kind;
  logic [ID_W-1:0]      op_id;
  logic [PAYLOAD_W-1:0] op_pay;

  logic [IW-1:0]        head;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        idx_plus1;

  logic                 res_found;
  logic                 res_ovf;
  logic [ID_W-1:0]      res_id;
  logic [PAYLOAD_W-1:0] res_pay;

  assign idx_plus1 = idx + CW'(1);
  assign rd_addr   = cmd.rd_next ? phys(head, idx_plus1) : phys(head, idx);
  assign wr_addr   = cmd.wr_add ? phys(head, count) : phys(head, idx);
  assign wr_en     = cmd.wr_add | cmd.wr_shift;

  always_comb begin
    if (cmd.wr_add) begin
      wr_data.id  = op_id;
      wr_data.pay = op_pay;
    end else begin
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind <= ptt_kind_t'(in_kind);
      op_id   <= in_trans_id;
      op_pay  <= in_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx_plus1;
      end
      if (cmd.head_inc) begin
        head <= (head == IW'(MAX_PENDING - 1)) ? '0 : head + IW'(1);
      end
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      res_found <= 1'b0;
      res_ovf   <= 1'b0;
      res_id    <= '0;
      res_pay   <= '0;
    end else if (cmd.res_add) begin
      res_found <= 1'b1;
      res_id    <= op_id;
      res_pay   <= op_pay;
    end else if (cmd.res_hit) begin
      res_found <= 1'b1;
      res_id    <= rdata.id;
      res_pay   <= rdata.pay;
    end else if (cmd.res_ovf) begin
      res_ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= res_found;
      hit_id      <= res_id;
      hit_payload <= res_pay;
      entry_count <= COUNT_OUT_W'(count);
      overflow    <= res_ovf;
    end
  end

  always_comb begin
    sts.op_kind  = op_kind;
    sts.full     = (count == CW'(MAX_PENDING));
    sts.empty    = (count == '0);
    sts.match    = (rdata.id == op_id);
    sts.last     = (idx_plus1 == count);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

/* design/ptt_ctrl.sv */
// Controller state machine that sequences add, scan, pop and gap closing.
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  ptt_sts_t sts,
  output ptt_cmd_t cmd
);

  ptt_state_t state;
  ptt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.op_kind)
          KIND_ADD:       state_next = ST_FINISH;
          KIND_REM_FIRST: state_next = sts.empty ? ST_FINISH : ST_POP_WAIT;
          default:        state_next = sts.empty ? ST_FINISH : ST_SCAN_RD;
        endcase
      end
      ST_POP_WAIT: state_next = ST_FINISH;
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (sts.match) begin
          state_next = (sts.op_kind == KIND_FIND_REM) ? ST_SH_RD : ST_FINISH;
        end else begin
          state_next = sts.last ? ST_FINISH : ST_SCAN_RD;
        end
      end
      ST_SH_RD: begin
        state_next = sts.last ? ST_FINISH : ST_SH_WR;
      end
      ST_SH_WR: state_next = ST_SH_RD;
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.load_op   = in_valid;
        cmd.idx_clear = in_valid;
      end
      ST_EXEC: begin
        case (sts.op_kind)
          KIND_ADD: begin
            if (sts.full) begin
              cmd.res_ovf = 1'b1;
            end else begin
              cmd.wr_add    = 1'b1;
              cmd.count_inc = 1'b1;
              cmd.res_add   = 1'b1;
            end
          end
          KIND_REM_FIRST: begin
            cmd.mem_rd = !sts.empty;
          end
          default: begin
          end
        endcase
      end
      ST_POP_WAIT: begin
        cmd.res_hit   = 1'b1;
        cmd.head_inc  = 1'b1;
        cmd.count_dec = 1'b1;
      end
      ST_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
      end
      ST_SCAN_CMP: begin
        cmd.res_hit = sts.match;
        cmd.idx_inc = !sts.match && !sts.last;
      end
      ST_SH_RD: begin
        cmd.count_dec = sts.last;
        cmd.mem_rd    = !sts.last;
        cmd.rd_next   = 1'b1;
      end
      ST_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/pending_transaction_tracker_core.sv */
// Top level of the pending transaction tracker: controller, datapath and channel hookup.
// Add and any operation on an empty table respond without reading the memory, remove-first
// reads and pops the head entry, a find compares the stored entries in order, and
// find-and-remove then moves each younger entry one slot toward the head.
// One request is in flight at a time; the next beat is taken in the cycle after the response
// register loads. Synchronous reset clears head and count, with no clearing pass.
module pending_transaction_tracker_core
  import ptt_pkg::*;
#(
  parameter int MAX_PENDING = PTT_MAX_PENDING
) (
  input logic      clk,
  input logic      rst,
  ptt_req_if.sink  req,
  ptt_rsp_if.source rsp
);

  // The controller owns sequencing; the datapath owns every stored value.
  ptt_cmd_t cmd;
  ptt_sts_t sts;

  // Requests are taken only while the controller is idle. The response register in the
  // datapath holds a finished beat, so a new request can be accepted while it waits.
  assign req.ready = cmd.in_ready;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entries live in a ring memory starting at the head pointer. Finds walk it entry by entry,
  // reading each through the registered read port and then comparing it, and removal from the
  // middle closes the gap by copying each younger entry one slot toward the head.
  ptt_datapath #(
    .MAX_PENDING (MAX_PENDING)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (req.kind),
    .in_trans_id (req.trans_id),
    .in_payload  (req.payload),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .found       (rsp.found),
    .hit_id      (rsp.hit_id),
    .hit_payload (rsp.hit_payload),
    .entry_count (rsp.entry_count),
    .overflow    (rsp.overflow)
  );

endmodule
